FILE: rtl/core/assert_macros.svh
// Shared assertion macros for the normalizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define IRN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked while reset is asserted
`define IRN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/irn_pkg.sv
package irn_pkg;

    // Sizing
    localparam int CHANNELS      = 16;
    localparam int IDX_W         = $clog2(CHANNELS);
    localparam int CH_W          = 4;
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 15;
    localparam int LEVEL_W       = 16;
    localparam int CNT_W         = $clog2(FRACTION_BITS + 1);
    localparam int REM_W         = SAMPLE_BITS + 1;

    localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << FRACTION_BITS;

    // Command codes
    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_WR_DARK   = 2'd1;
    localparam logic [1:0] CMD_WR_BRIGHT = 2'd2;

    // Calibration mode codes
    localparam logic [1:0] MODE_NORMAL     = 2'd0;
    localparam logic [1:0] MODE_CAP_DARK   = 2'd1;
    localparam logic [1:0] MODE_CAP_BRIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [CH_W-1:0]        channel;
        logic [7:0]             byte_hi;
        logic [7:0]             byte_lo;
        logic [SAMPLE_BITS-1:0] load_value;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0]        out_channel;
        logic [LEVEL_W-1:0]     level;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   below_flag;
        logic                   above_flag;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic step;
        logic emit;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic step_last;
        logic out_full;
    } t_sts;

endpackage

FILE: rtl/core/irn_ctrl.sv
`include "assert_macros.svh"

module irn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  irn_pkg::t_sts i_sts,
    output irn_pkg::t_ctl o_ctl,
    output logic          o_in_stall
);
    import irn_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = i_sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_sts.step_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_full || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_ctl.capture = i_in_valid;
            end
            S_PREP: begin
                o_ctl.prep = 1'b1;
            end
            S_DIV: begin
                o_ctl.step = 1'b1;
            end
            S_DONE: begin
                o_ctl.emit = !i_sts.out_full || !i_out_stall;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    `IRN_ASSERT_NEXT(a_accept_to_prep, i_clk, i_rst_n, i_in_valid && !o_in_stall,
                     r_state == S_PREP)
    `IRN_ASSERT_NEXT(a_emit_to_idle, i_clk, i_rst_n, o_ctl.emit, r_state == S_IDLE)
    `IRN_ASSERT_IMPLY(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)

endmodule

FILE: rtl/core/irn_dpath.sv
`include "assert_macros.svh"

module irn_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  irn_pkg::t_ctl i_ctl,
    input  irn_pkg::t_in  i_in,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_wr_data,
    input  logic          i_out_stall,
    output irn_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output irn_pkg::t_out o_out
);
    import irn_pkg::*;

    // Calibration tables and mode
    logic [SAMPLE_BITS-1:0] r_dark   [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_bright [CHANNELS];
    logic [1:0]             r_mode;

    // Item registers
    logic                   r_is_write;
    logic [CH_W-1:0]        r_ch;
    logic [SAMPLE_BITS-1:0] r_s;

    // Divider and result registers
    logic [REM_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_dvs;
    logic [CNT_W-1:0]       r_cnt;
    logic [LEVEL_W-1:0]     r_level;
    logic                   r_below;
    logic                   r_above;
    logic                   r_out_valid;
    t_out                   r_out;

    logic                   in_is_write;
    logic [IDX_W-1:0]       in_idx;
    logic [IDX_W-1:0]       idx;
    logic [SAMPLE_BITS-1:0] dark;
    logic [SAMPLE_BITS-1:0] bright;
    logic [REM_W-1:0]       num;
    logic [REM_W-1:0]       span;
    logic                   num_zero;
    logic                   span_zero;
    logic                   num_neg;
    logic                   span_neg;
    logic [REM_W-1:0]       num_abs;
    logic [REM_W-1:0]       span_abs;
    logic [SAMPLE_BITS-1:0] an;
    logic [SAMPLE_BITS-1:0] as_abs;
    logic                   over;
    logic                   ge;
    logic [REM_W-1:0]       diff;
    logic [REM_W-1:0]       rem_next;

    assign in_is_write = (i_in.cmd == CMD_WR_DARK) || (i_in.cmd == CMD_WR_BRIGHT);
    assign in_idx      = i_in.channel[IDX_W-1:0];
    assign idx         = r_ch[IDX_W-1:0];

    // Signed numerator and span against the stored calibration
    assign dark      = r_dark[idx];
    assign bright    = r_bright[idx];
    assign num       = {1'b0, r_s} - {1'b0, dark};
    assign span      = {1'b0, bright} - {1'b0, dark};
    assign num_zero  = (num == '0);
    assign span_zero = (span == '0);
    assign num_neg   = num[REM_W-1];
    assign span_neg  = span[REM_W-1];
    assign num_abs   = num_neg ? (~num + REM_W'(1)) : num;
    assign span_abs  = span_neg ? (~span + REM_W'(1)) : span;
    assign an        = num_abs[SAMPLE_BITS-1:0];
    assign as_abs    = span_abs[SAMPLE_BITS-1:0];
    assign over      = an > as_abs;

    // Restoring divider step
    assign ge       = r_rem >= {1'b0, r_dvs};
    assign diff     = ge ? (r_rem - {1'b0, r_dvs}) : r_rem;
    assign rem_next = {diff[REM_W-2:0], 1'b0};

    // Status to the controller
    assign o_sts.need_div  = !r_is_write && !num_zero && !span_zero
                             && (num_neg == span_neg) && !over;
    assign o_sts.step_last = (r_cnt == CNT_W'(FRACTION_BITS));
    assign o_sts.out_full  = r_out_valid;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Calibration tables: direct loads on transfer, maxima capture after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_dark[i]   <= '0;
                r_bright[i] <= '0;
            end
        end else if (i_ctl.capture) begin
            if (i_in.cmd == CMD_WR_DARK) r_dark[in_idx] <= i_in.load_value;
            if (i_in.cmd == CMD_WR_BRIGHT) r_bright[in_idx] <= i_in.load_value;
        end else if (i_ctl.prep && !r_is_write) begin
            if (r_mode == MODE_CAP_DARK && r_s > dark) r_dark[idx] <= r_s;
            if (r_mode == MODE_CAP_BRIGHT && r_s > bright) r_bright[idx] <= r_s;
        end
    end

    // Latch the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_is_write <= in_is_write;
            r_ch       <= i_in.channel;
            r_s        <= in_is_write ? i_in.load_value : {i_in.byte_hi[3:0], i_in.byte_lo};
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.prep) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Settle special cases, load divider, then shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_ctl.prep) begin
            r_rem   <= {1'b0, an};
            r_dvs   <= as_abs;
            r_level <= '0;
            r_below <= 1'b0;
            r_above <= 1'b0;
            priority if (r_is_write || num_zero) begin
                r_level <= '0;
            end else if (span_zero) begin
                if (num_neg) begin
                    r_below <= 1'b1;
                end else begin
                    r_level <= ONE_LEVEL;
                    r_above <= 1'b1;
                end
            end else if (num_neg != span_neg) begin
                r_below <= 1'b1;
            end else if (over) begin
                r_level <= ONE_LEVEL;
                r_above <= 1'b1;
            end else begin
                r_level <= '0;
            end
        end else if (i_ctl.step) begin
            r_rem   <= rem_next;
            r_level <= {r_level[LEVEL_W-2:0], ge};
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out.out_channel <= r_ch;
            r_out.level       <= r_level;
            r_out.sample      <= r_s;
            r_out.below_flag  <= r_below;
            r_out.above_flag  <= r_above;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `IRN_ASSERT_IMPLY(a_flags_excl, i_clk, i_rst_n, o_out_valid, !(o_out.below_flag && o_out.above_flag))
    `IRN_ASSERT_IMPLY(a_level_range, i_clk, i_rst_n, o_out_valid, o_out.level <= ONE_LEVEL)
    `IRN_ASSERT_IMPLY(a_above_is_one, i_clk, i_rst_n, o_out_valid && o_out.above_flag, o_out.level == ONE_LEVEL)
    `IRN_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

endmodule

FILE: rtl/core/ir_array_calibrated_normalizer_top.sv
// Calibrated normalizer for a 16-channel IR sensor array. A sample item
// assembles a 12-bit reading from the low nibble of the first SPI byte and
// the second byte and returns (sample - dark) / (bright - dark) for its
// channel, clamped to 0..1 in unsigned Q1.15 with below/above clamp flags;
// write items load a dark or bright word and echo it with level 0. One item
// is in work at a time: a sample needing a true division passes capture,
// operand setup, 16 steps of the restoring divider and output load before
// the next transfer; writes and clamped or zero cases skip the divider. The
// output register lets the next item be taken while a result is stalled.
// Both tables and the mode register clear on reset; the user must change
// mode only while the block is idle; the block itself does not enforce it.
module ir_array_calibrated_normalizer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  irn_pkg::t_in  i_in,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_wr_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output irn_pkg::t_out o_out
);
    import irn_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequencer
    irn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_in_stall  (o_in_stall)
    );

    // Tables, divider and output register
    irn_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out)
    );

endmodule

FILE: verif/irn_result_checker.sv
module irn_result_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  irn_pkg::t_in           i_in,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_wr_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  irn_pkg::t_out          i_out,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_result_count,
    output int                     o_clamp_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import irn_pkg::*;

    logic [SAMPLE_BITS-1:0] dark_words   [CHANNELS];
    logic [SAMPLE_BITS-1:0] bright_words [CHANNELS];
    logic [1:0]             cal_mode;
    t_out                   level_expect_q [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_clamp_count  = 0;
        cal_mode       = MODE_NORMAL;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t ERROR result %0d %s: got %0d, expected %0d",
                 $realtime, o_result_count, what, got, want);
    endtask

    // Work out the result of one item against the calibration as it stands
    function automatic t_out predict_level(input t_in item,
                                           input logic [SAMPLE_BITS-1:0] drk,
                                           input logic [SAMPLE_BITS-1:0] brt);
        t_out res;
        int   num;
        int   span;
        int   mag_num;
        int   mag_span;
        res = '0;
        res.out_channel = item.channel;
        // Writes echo the loaded word with level zero
        if (item.cmd == CMD_WR_DARK || item.cmd == CMD_WR_BRIGHT) begin
            res.sample = item.load_value;
            return res;
        end
        res.sample = {item.byte_hi[3:0], item.byte_lo};
        num      = int'(res.sample) - int'(drk);
        span     = int'(brt) - int'(drk);
        mag_num  = (num < 0) ? -num : num;
        mag_span = (span < 0) ? -span : span;
        if (num != 0) begin
            // Flat span: the numerator sign alone decides; otherwise signs must agree
            if (span == 0 ? (num < 0) : ((num > 0) != (span > 0))) begin
                res.below_flag = 1'b1;
            end else if (span == 0 || mag_num > mag_span) begin
                res.level      = ONE_LEVEL;
                res.above_flag = 1'b1;
            end else begin
                res.level = LEVEL_W'((mag_num << FRACTION_BITS) / mag_span);
            end
        end
        return res;
    endfunction

    // Watch both channels and the mode port on every edge
    always @(posedge i_clk) begin
        t_out                   got;
        t_out                   want;
        t_in                    item;
        logic [IDX_W-1:0]       slot;
        if (!i_rst_n) begin
            foreach (dark_words[k]) begin
                dark_words[k]   = '0;
                bright_words[k] = '0;
            end
            cal_mode = MODE_NORMAL;
            level_expect_q.delete();
        end else begin
            // Compare the result that transfers at this edge with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got = i_out;
                o_result_count++;
                if (level_expect_q.size() == 0) begin
                    report_mismatch("arrived with nothing outstanding, channel",
                                    got.out_channel, -1);
                end else begin
                    want = level_expect_q.pop_front();
                    if (got.out_channel !== want.out_channel)
                        report_mismatch("out_channel", got.out_channel, want.out_channel);
                    if (got.level !== want.level)
                        report_mismatch("level", got.level, want.level);
                    if (got.sample !== want.sample)
                        report_mismatch("sample", got.sample, want.sample);
                    if (got.below_flag !== want.below_flag)
                        report_mismatch("below_flag", got.below_flag, want.below_flag);
                    if (got.above_flag !== want.above_flag)
                        report_mismatch("above_flag", got.above_flag, want.above_flag);
                    if (want.below_flag || want.above_flag)
                        o_clamp_count++;
                end
            end
            // Predict from the old tables, then apply the write or the capture
            if (i_in_valid && !i_in_stall) begin
                item = i_in;
                slot = IDX_W'(item.channel % CHANNELS);
                want = predict_level(item, dark_words[slot], bright_words[slot]);
                level_expect_q.push_back(want);
                if (item.cmd == CMD_WR_DARK) begin
                    dark_words[slot] = item.load_value;
                end else if (item.cmd == CMD_WR_BRIGHT) begin
                    bright_words[slot] = item.load_value;
                end else if (cal_mode == MODE_CAP_DARK && want.sample > dark_words[slot]) begin
                    dark_words[slot] = want.sample;
                end else if (cal_mode == MODE_CAP_BRIGHT
                             && want.sample > bright_words[slot]) begin
                    bright_words[slot] = want.sample;
                end
            end
            if (i_cfg_wr_en) begin
                cal_mode = i_cfg_wr_data;
            end
        end
        o_pending = level_expect_q.size();
    end

endmodule

FILE: verif/tb_ir_array_calibrated_normalizer_top.sv
module tb_ir_array_calibrated_normalizer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import irn_pkg::*;

    localparam int         CLK_PERIOD      = 10;
    localparam int         RESET_CYCLES    = 6;
    localparam int         SETTLE_CYCLES   = 30;
    localparam int         LONG_HOLD       = 300;
    localparam int         HOLD_BURST      = 40;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 210;
    // Codes the block must treat as their plain counterparts
    localparam logic [1:0] CMD_SPARE       = 2'd3;
    localparam logic [1:0] MODE_SPARE      = 2'd3;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    t_in        in_item     = '0;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = MODE_NORMAL;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    t_out       out_item;

    int         fail_count;
    int         pending;
    int         result_count;
    int         clamp_count;
    int         sent_count  = 0;
    int         quiet_cycles = 0;
    bit         src_idle    = 1'b0;
    bit         sink_idle   = 1'b0;
    bit         hold_req    = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    ir_array_calibrated_normalizer_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in          (in_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out         (out_item)
    );

    irn_result_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in           (in_item),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out          (out_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_clamp_count  (clamp_count)
    );

    // Build a reading for one channel; the upper nibble of the first byte is noise
    function automatic t_in mk_sample(input logic [3:0] ch, input logic [11:0] reading);
        t_in item;
        item            = '0;
        item.cmd        = CMD_SAMPLE;
        item.channel    = ch;
        item.byte_hi    = {4'($urandom), reading[11:8]};
        item.byte_lo    = reading[7:0];
        item.load_value = 12'($urandom);
        return item;
    endfunction

    function automatic t_in mk_write(input logic [1:0] cmd, input logic [3:0] ch,
                                     input logic [11:0] word);
        t_in item;
        item            = '0;
        item.cmd        = cmd;
        item.channel    = ch;
        item.byte_hi    = 8'($urandom);
        item.byte_lo    = 8'($urandom);
        item.load_value = word;
        return item;
    endfunction

    // Mostly readings, with calibration loads mixed in to move the window
    function automatic t_in random_item();
        t_in item;
        int  pick;
        item            = '0;
        item.channel    = 4'($urandom);
        item.byte_hi    = 8'($urandom);
        item.byte_lo    = 8'($urandom);
        item.load_value = 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            item.cmd = CMD_WR_DARK;
        end else if (pick < 24) begin
            item.cmd = CMD_WR_BRIGHT;
        end else if (pick < 30) begin
            item.cmd = CMD_SPARE;
        end else begin
            item.cmd = CMD_SAMPLE;
        end
        // Pin the word or the reading to an end of its range now and then
        if ($urandom_range(0, 7) == 0)
            item.load_value = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        if ($urandom_range(0, 7) == 0)
            {item.byte_hi[3:0], item.byte_lo} = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        return item;
    endfunction

    // Offer one item, optionally after a gap, and hold it until it transfers
    task automatic send_item(input t_in item);
        int gap;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    // Stop offering, let every result come back, then give the block time to settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_mode(input logic [1:0] mode);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: random stall bursts, plus one long hold on request
    initial begin : result_sink
        int burst;
        burst = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (burst > 0) begin
                out_stall <= 1'b1;
                burst--;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 8);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ir_array_calibrated_normalizer_top");
            $finish;
        end
    end

    initial begin : stimulus
        t_in        item;
        logic [1:0] plan [PHASES];
        int         n;
        plan = '{MODE_CAP_DARK, MODE_NORMAL, MODE_CAP_BRIGHT, MODE_SPARE,
                 MODE_NORMAL, MODE_CAP_BRIGHT, MODE_CAP_DARK, MODE_NORMAL};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        change_mode(MODE_NORMAL);

        // Cleared tables: zero numerator, then a positive one over a flat span
        send_item(mk_sample(4'd0, 12'd0));
        send_item(mk_sample(4'd0, 12'hfff));
        // Rising window: below, at dark, inside, exactly at bright
        send_item(mk_write(CMD_WR_DARK, 4'd1, 12'd100));
        send_item(mk_write(CMD_WR_BRIGHT, 4'd1, 12'hfff));
        send_item(mk_sample(4'd1, 12'd50));
        send_item(mk_sample(4'd1, 12'd100));
        send_item(mk_sample(4'd1, 12'd2000));
        send_item(mk_sample(4'd1, 12'hfff));
        item = mk_sample(4'd1, 12'd3000);
        item.cmd = CMD_SPARE;
        send_item(item);
        // Inverted window: opposite signs, overshoot, inside
        send_item(mk_write(CMD_WR_DARK, 4'd2, 12'd3000));
        send_item(mk_write(CMD_WR_BRIGHT, 4'd2, 12'd1000));
        send_item(mk_sample(4'd2, 12'd3500));
        send_item(mk_sample(4'd2, 12'd500));
        send_item(mk_sample(4'd2, 12'd2000));
        // Flat span away from zero: negative and positive numerators
        send_item(mk_write(CMD_WR_DARK, 4'd3, 12'd2000));
        send_item(mk_write(CMD_WR_BRIGHT, 4'd3, 12'd2000));
        send_item(mk_sample(4'd3, 12'd100));
        send_item(mk_sample(4'd3, 12'd3000));
        // Widest inverted window on the last channel
        send_item(mk_write(CMD_WR_DARK, 4'd15, 12'hfff));
        send_item(mk_write(CMD_WR_BRIGHT, 4'd15, 12'd0));
        send_item(mk_sample(4'd15, 12'd0));
        // Capture modes raise the selected word after the result is formed
        change_mode(MODE_CAP_DARK);
        send_item(mk_sample(4'd5, 12'd1000));
        send_item(mk_sample(4'd5, 12'd500));
        change_mode(MODE_CAP_BRIGHT);
        send_item(mk_sample(4'd5, 12'd3000));
        send_item(mk_sample(4'd5, 12'd2000));
        change_mode(MODE_SPARE);
        send_item(mk_sample(4'd5, 12'd4000));
        send_item(mk_sample(4'd5, 12'd4000));

        // Random phases, one mode each; the last runs without idling
        for (int phase = 0; phase < PHASES; phase++) begin
            change_mode(plan[phase]);
            src_idle  = (phase != PHASES - 1) && (phase % 3 != 2);
            sink_idle = (phase != PHASES - 1) && (phase % 3 != 1);
            n = 0;
            if (phase == 1) begin
                // Back up the block against a stalled receiver
                src_idle = 1'b0;
                hold_req = 1'b1;
                repeat (HOLD_BURST) begin
                    send_item(random_item());
                    n++;
                end
                src_idle = 1'b1;
            end
            while (n < ITEMS_PER_PHASE) begin
                send_item(random_item());
                n++;
            end
        end
        drain();

        $display("Run covered %0d input transfers over all commands and calibration modes",
                 sent_count);
        $display("%0d results compared, %0d of them clamped, %0d mismatches",
                 result_count, clamp_count, fail_count);
        if (fail_count == 0) begin
            $display("PASS ir_array_calibrated_normalizer_top");
        end else begin
            $display("FAIL ir_array_calibrated_normalizer_top");
        end
        $finish;
    end

endmodule
